@@ hw/rtl/pst_pkg.sv @@
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants
// Fixed sensor limits, Q formats and the divider handshake struct.
// ----------------------------------------------------------------------------
`default_nettype none
package pst_pkg;
  localparam int NumRegs = 8;
  localparam logic [9:0] P1WideLo = 10'd50;
  localparam logic [9:0] P1WideHi = 10'd850;
  localparam logic [9:0] P2WideLo = 10'd150;
  localparam logic [9:0] P2WideHi = 10'd950;
  localparam logic [9:0] StWideLo = 10'd100;
  localparam logic [9:0] StWideHi = 10'd900;
  localparam logic [9:0] HardBrake = 10'd500;
  localparam logic [14:0] TorqueMax = 15'd20480;

  localparam logic [2:0] REG_P1_LO = 3'd0;
  localparam logic [2:0] REG_P1_HI = 3'd1;
  localparam logic [2:0] REG_P2_LO = 3'd2;
  localparam logic [2:0] REG_P2_HI = 3'd3;
  localparam logic [2:0] REG_ST_LE = 3'd4;
  localparam logic [2:0] REG_ST_RE = 3'd5;
  localparam logic [2:0] REG_ST_LF = 3'd6;
  localparam logic [2:0] REG_ST_RF = 3'd7;

  localparam logic [1:0] DIR_STRAIGHT = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_DISAGREE = 3'd2;
  localparam logic [2:0] ST_SAME = 3'd3;
  localparam logic [2:0] ST_BRAKE = 3'd4;

  // divider request: numerator (10b) * 65536 / span (10b)
  typedef struct packed {
    logic       start;
    logic [9:0] num;
    logic [9:0] span;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ hw/rtl/pedal_steer_torque_split.sv @@
// ----------------------------------------------------------------------------
// pedal_steer_torque_split: pedal/steering torque split controller
// Validates sensors, normalizes pedals and splits torque left and right.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A sample runs three divisions through one
// shared bit-serial divider (pedal one, pedal two, the steering fraction);
// each is a launch, 26 shift-subtract steps and a pickup of the quotient.
// Then come an evaluation step and one multiply step per wheel, after which
// the result sits in an output register until it is taken. The block is
// ready for the next sample in the cycle after the result transfer, so a
// new sample is not taken before the last result is transferred. Registers
// are written over the cfg port while idle. Brake and disagreement
// persistence count samples, not time.
`default_nettype none
module pedal_steer_torque_split
  import pst_pkg::*;
#(
  parameter int BRAKE_DELAY_SAMPLES = 500,
  parameter int DISAGREE_DELAY_SAMPLES = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pedal1_sample[9:0], pedal2_sample[19:10], steer_sample[29:20],
  // brake_sample[39:30]
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // left_torque[14:0], right_torque[29:15], steer_dir[31:30], status[34:32]
  output logic [39:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_D1   = 4'd1;
  localparam logic [3:0] S_D2   = 4'd2;
  localparam logic [3:0] S_D3   = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [9:0] regs [NumRegs];
  logic [3:0] state;
  logic       started;
  logic [9:0] p1, p2, st, br;
  logic [16:0] n1, n2, frac;
  logic [14:0] torque, left, right;
  logic [1:0]  dir;
  logic [2:0]  stat;
  logic        brake_latched;
  logic [15:0] brake_count, disagree_count;
  logic        dis_cut;
  div_req_t    dreq;
  div_rsp_t    drsp;

  pst_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // clamped pedals
  logic [9:0] c1, c2;
  always_comb begin
    c1 = p1;
    if (c1 > regs[REG_P1_HI]) c1 = regs[REG_P1_HI];
    if (c1 < regs[REG_P1_LO]) c1 = regs[REG_P1_LO];
    c2 = p2;
    if (c2 > regs[REG_P2_HI]) c2 = regs[REG_P2_HI];
    if (c2 < regs[REG_P2_LO]) c2 = regs[REG_P2_LO];
  end

  // steering side select and span
  logic       turn_r, turn_l;
  logic [9:0] s_num, s_span;
  always_comb begin
    turn_r = st > regs[REG_ST_RE];
    turn_l = !turn_r && (st < regs[REG_ST_LE]);
    s_num  = '0;
    s_span = '0;
    if (turn_r && regs[REG_ST_RF] > regs[REG_ST_RE]) begin
      s_num  = ((st > regs[REG_ST_RF]) ? regs[REG_ST_RF] : st) - regs[REG_ST_RE];
      s_span = regs[REG_ST_RF] - regs[REG_ST_RE];
    end else if (turn_l && regs[REG_ST_LF] < regs[REG_ST_LE]) begin
      s_num  = regs[REG_ST_LE] - ((st < regs[REG_ST_LF]) ? regs[REG_ST_LF] : st);
      s_span = regs[REG_ST_LE] - regs[REG_ST_LF];
    end
  end

  // divider launch
  always_comb begin
    dreq = '0;
    if (!started) begin
      unique case (state)
        S_D1: begin
          dreq.start = 1'b1;
          dreq.num   = c1 - regs[REG_P1_LO];
          dreq.span  = (regs[REG_P1_HI] > regs[REG_P1_LO]) ?
                       regs[REG_P1_HI] - regs[REG_P1_LO] : 10'd0;
        end
        S_D2: begin
          dreq.start = 1'b1;
          dreq.num   = c2 - regs[REG_P2_LO];
          dreq.span  = (regs[REG_P2_HI] > regs[REG_P2_LO]) ?
                       regs[REG_P2_HI] - regs[REG_P2_LO] : 10'd0;
        end
        S_D3: begin
          dreq.start = 1'b1;
          dreq.num   = s_num;
          dreq.span  = s_span;
        end
        default: dreq = '0;
      endcase
    end
  end

  // evaluation terms
  logic [17:0] sum;
  logic [16:0] diff;
  logic        fault, dis_now;
  logic [15:0] bc_inc, dc_next;
  assign sum  = {1'b0, n1} + {1'b0, n2};
  assign diff = (n1 > n2) ? n1 - n2 : n2 - n1;
  assign dis_now = ({4'd0, diff} * 21'd10) > 21'd65536;
  assign bc_inc = (brake_latched && brake_count != 16'hFFFF) ?
                  brake_count + 16'd1 : brake_count;
  assign dc_next = dis_now ? ((disagree_count != 16'hFFFF) ?
                   disagree_count + 16'd1 : disagree_count) : 16'd0;
  assign dis_cut = dc_next >= 16'(DISAGREE_DELAY_SAMPLES);
  assign fault = p1 < P1WideLo || p1 > P1WideHi || p2 < P2WideLo ||
                 p2 > P2WideHi || st < StWideLo || st > StWideHi;

  // status, direction and brake plausibility for the sample under evaluation
  logic [1:0]  dir_next;
  logic [2:0]  stat_next;
  logic        brake_latched_next, brake_cut;
  logic [15:0] brake_count_next;
  always_comb begin
    brake_latched_next = brake_latched;
    brake_count_next   = bc_inc;
    brake_cut          = 1'b0;
    dir_next  = turn_r ? DIR_RIGHT : (turn_l ? DIR_LEFT : DIR_STRAIGHT);
    stat_next = ST_OK;
    if (fault) begin
      dir_next  = DIR_STRAIGHT;
      stat_next = ST_RANGE;
    end else begin
      if (br > HardBrake && sum > 18'd32768) begin
        if (!brake_latched) begin
          brake_latched_next = 1'b1;
          brake_count_next   = '0;
        end else if (bc_inc >= 16'(BRAKE_DELAY_SAMPLES)) brake_cut = 1'b1;
      end else if (br < HardBrake && ({3'd0, sum} * 21'd10) < 21'd65536) begin
        brake_latched_next = 1'b0;
        brake_count_next   = '0;
      end else if (brake_latched) brake_cut = 1'b1;
      // disagreement wins over identical pedals, which win over brake cut
      if (dis_cut) stat_next = ST_DISAGREE;
      else if (c1 == c2) stat_next = ST_SAME;
      else if (brake_cut) stat_next = ST_BRAKE;
      else stat_next = ST_OK;
    end
  end

  // shared multiplier: torque * (131072 +/- frac) >> 17
  logic        mul_plus;
  logic [17:0] factor;
  logic [32:0] prod;
  logic [15:0] prod_sh;
  logic [14:0] prod_sat;
  assign factor  = mul_plus ? 18'd131072 + {1'b0, frac} : 18'd131072 - {1'b0, frac};
  assign prod    = torque * factor;
  assign prod_sh = prod[32:17];
  assign prod_sat = (prod_sh > {1'b0, TorqueMax}) ? TorqueMax : prod_sh[14:0];
  always_comb begin
    mul_plus = 1'b0;
    if (state == S_MUL1) mul_plus = (dir == DIR_RIGHT);
    else mul_plus = (dir == DIR_LEFT);
  end

  logic [24:0] t_wide;
  assign t_wide = sum * 7'd80;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      started <= 1'b0;
      m_tvalid <= 1'b0;
      brake_latched <= 1'b0;
      brake_count <= '0;
      disagree_count <= '0;
      regs[REG_P1_LO] <= 10'd100; regs[REG_P1_HI] <= 10'd800;
      regs[REG_P2_LO] <= 10'd200; regs[REG_P2_HI] <= 10'd900;
      regs[REG_ST_LE] <= 10'd490; regs[REG_ST_RE] <= 10'd510;
      regs[REG_ST_LF] <= 10'd200; regs[REG_ST_RF] <= 10'd800;
    end else begin
      if (cfg_valid && cfg_ready) regs[cfg_index] <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            {br, st, p2, p1} <= s_tdata;
            state <= S_D1;
            started <= 1'b0;
          end
        end
        S_D1, S_D2, S_D3: begin
          // hold the launch off until the quotient is back
          started <= !drsp.done;
          if (drsp.done) begin
            if (state == S_D1) begin n1 <= drsp.quo; state <= S_D2; end
            else if (state == S_D2) begin n2 <= drsp.quo; state <= S_D3; end
            else begin frac <= drsp.quo; state <= S_EVAL; end
          end
        end
        S_EVAL: begin
          disagree_count <= dc_next;
          brake_count <= brake_count_next;
          brake_latched <= brake_latched_next;
          torque <= t_wide[23:9];
          dir <= dir_next;
          stat <= stat_next;
          state <= S_MUL1;
        end
        S_MUL1: begin
          left <= (dir == DIR_STRAIGHT) ? ((torque > TorqueMax) ? TorqueMax : torque)
                                        : prod_sat;
          state <= S_MUL2;
        end
        S_MUL2: begin
          right <= (dir == DIR_STRAIGHT) ? left : prod_sat;
          m_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // zero torques whenever status is not ok
  always_comb begin
    m_tdata = '0;
    m_tdata[34:32] = stat;
    m_tdata[31:30] = dir;
    if (stat == ST_OK) begin
      m_tdata[14:0]  = left;
      m_tdata[29:15] = right;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_busy_noready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while result pending");
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34:32] == ST_RANGE |-> m_tdata[31:30] == DIR_STRAIGHT)
    else $error("range fault with steer dir");
endmodule
`default_nettype wire

@@ hw/rtl/pst_div.sv @@
// ----------------------------------------------------------------------------
// pst_div: restoring divider
// Computes floor(num * 65536 / span), one quotient bit per cycle; span 0 -> 0.
// ----------------------------------------------------------------------------
`default_nettype none
module pst_div
  import pst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  // dividend is num << 16 (26 bits); quotient never exceeds 17 bits when num <= span
  logic [25:0] dvd;
  logic [10:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [9:0]  span;
  logic [10:0] trial;
  logic [10:0] shifted;

  assign shifted = {rem[9:0], dvd[25]};
  assign trial   = shifted - {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == 5'd1);
      if (req.start) begin
        busy <= 1'b1;
        dvd  <= {req.num, 16'd0};
        rem  <= '0;
        span <= req.span;
        cnt  <= 5'd26;
      end else if (busy) begin
        if (!trial[10] && span != 10'd0) begin
          rem <= trial;
          dvd <= {dvd[24:0], 1'b1};
        end else begin
          rem <= shifted;
          dvd <= {dvd[24:0], 1'b0};
        end
        cnt  <= cnt - 5'd1;
        busy <= (cnt != 5'd1);
      end
    end
  end

  // after the last shift dvd holds the quotient bits
  assign rsp = {done, (span == 10'd0) ? 17'd0 : dvd[16:0]};
endmodule
`default_nettype wire

@@ tb/tb_pedal_steer_torque_split.sv @@
// ----------------------------------------------------------------------------
// tb_pedal_steer_torque_split: self-checking bench for the torque split block
// Drives sensor samples over the stream port with random gaps, predicts each
// torque result in a scoreboard and compares every field of every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_pedal_steer_torque_split;
  import pst_pkg::*;

  localparam int BrakeDelay = 500;
  localparam int DisagreeDelay = 100;
  localparam int CycleLimit = 1500000;

  typedef struct packed {
    logic [9:0] brake;
    logic [9:0] steer;
    logic [9:0] pedal2;
    logic [9:0] pedal1;
  } sample_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [2:0]  status;
    logic [1:0]  dir;
    logic [14:0] right;
    logic [14:0] left;
  } torque_t;

  // Scoreboard: own copy of the registers and persistence state, and the
  // queue of torque results still owed by the block.
  class torque_scoreboard;
    logic [9:0]  regs[NumRegs];
    bit          brake_latched;
    int unsigned brake_count;
    int unsigned disagree_count;
    torque_t     owed[$];
    int          errors;

    function void reset_state();
      regs[REG_P1_LO] = 100; regs[REG_P1_HI] = 800;
      regs[REG_P2_LO] = 200; regs[REG_P2_HI] = 900;
      regs[REG_ST_LE] = 490; regs[REG_ST_RE] = 510;
      regs[REG_ST_LF] = 200; regs[REG_ST_RF] = 800;
      brake_latched = 0;
      brake_count = 0;
      disagree_count = 0;
      owed.delete();
      errors = 0;
    endfunction

    function longint unsigned frac(longint unsigned num, longint unsigned span);
      if (span == 0) return 0;
      return (num * 65536) / span;
    endfunction

    function longint unsigned sat(longint unsigned v);
      return v > TorqueMax ? TorqueMax : v;
    endfunction

    // Predict the torque result of one accepted sample and advance state.
    function void note_sample(sample_t s);
      longint unsigned c1, c2, n1, n2, diff, sum, t, f, lo, hi, el, er, fl, fr, sc;
      bit fault, dis_cut, brake_cut;
      torque_t r;
      r = '0;
      brake_cut = 0;
      if (brake_latched && brake_count < 65535) brake_count++;
      lo = regs[REG_P1_LO]; hi = regs[REG_P1_HI];
      c1 = s.pedal1 > hi ? hi : s.pedal1;
      if (c1 < lo) c1 = lo;
      n1 = hi <= lo ? 0 : frac(c1 - lo, hi - lo);
      lo = regs[REG_P2_LO]; hi = regs[REG_P2_HI];
      c2 = s.pedal2 > hi ? hi : s.pedal2;
      if (c2 < lo) c2 = lo;
      n2 = hi <= lo ? 0 : frac(c2 - lo, hi - lo);
      diff = n1 > n2 ? n1 - n2 : n2 - n1;
      if (diff * 10 > 65536) begin
        if (disagree_count < 65535) disagree_count++;
      end else begin
        disagree_count = 0;
      end
      dis_cut = disagree_count >= DisagreeDelay;
      fault = s.pedal1 < P1WideLo || s.pedal1 > P1WideHi || s.pedal2 < P2WideLo ||
              s.pedal2 > P2WideHi || s.steer < StWideLo || s.steer > StWideHi;
      if (fault) begin
        r.status = ST_RANGE;
      end else begin
        el = regs[REG_ST_LE]; er = regs[REG_ST_RE];
        fl = regs[REG_ST_LF]; fr = regs[REG_ST_RF];
        sum = n1 + n2;
        t = (sum * 80) >> 9;
        if (s.steer > er) begin
          sc = s.steer > fr ? fr : s.steer;
          r.dir = DIR_RIGHT;
          f = fr > er ? frac(sc - er, fr - er) : 0;
          r.left = 15'(sat((t * (131072 + f)) >> 17));
          r.right = 15'(sat((t * (131072 - f)) >> 17));
        end else if (s.steer < el) begin
          sc = s.steer < fl ? fl : s.steer;
          r.dir = DIR_LEFT;
          f = fl < el ? frac(el - sc, el - fl) : 0;
          r.left = 15'(sat((t * (131072 - f)) >> 17));
          r.right = 15'(sat((t * (131072 + f)) >> 17));
        end else begin
          r.left = 15'(sat(t));
          r.right = r.left;
        end
        if (s.brake > HardBrake && sum > 32768) begin
          if (!brake_latched) begin
            brake_latched = 1;
            brake_count = 0;
          end else if (brake_count >= BrakeDelay) begin
            brake_cut = 1;
          end
        end else if (s.brake < HardBrake && sum * 10 < 65536) begin
          brake_latched = 0;
          brake_count = 0;
        end else if (brake_latched) begin
          brake_cut = 1;
        end
        if (dis_cut) r.status = ST_DISAGREE;
        else if (c1 == c2) r.status = ST_SAME;
        else if (brake_cut) r.status = ST_BRAKE;
        if (r.status != ST_OK) begin
          r.left = '0;
          r.right = '0;
        end
      end
      owed.push_back(r);
    endfunction

    function void check_result(torque_t got);
      torque_t exp_r;
      if (owed.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      if (got.left !== exp_r.left) begin
        $error("left_torque: expected %0d, got %0d", exp_r.left, got.left);
        errors++;
      end
      if (got.right !== exp_r.right) begin
        $error("right_torque: expected %0d, got %0d", exp_r.right, got.right);
        errors++;
      end
      if (got.dir !== exp_r.dir) begin
        $error("steer_dir: expected %0d, got %0d", exp_r.dir, got.dir);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  torque_scoreboard sb;
  int unsigned cycles = 0;
  bit          hold_off = 0;  // long receiver stall requested by the sender

  pedal_steer_torque_split #(
    .BRAKE_DELAY_SAMPLES(BrakeDelay),
    .DISAGREE_DELAY_SAMPLES(DisagreeDelay)
  ) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall before each transfer, or one long hold-off on request.
  initial begin
    int gap;
    bit held;
    held = 0;
    sb = new();
    sb.reset_state();
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1;
        repeat (400) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      repeat (gap) @(posedge clk);
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(torque_t'(m_tdata));
      m_tready <= 0;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.regs[idx] = val;
    @(posedge clk);
  endtask

  // Offer one sample after a random gap; hold until the transfer.
  task automatic send_sample(sample_t s, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= s;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(s);
  endtask

  // Wait for every owed result, then let the block settle before config.
  task automatic drain();
    s_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(bit wild);
    sample_t s;
    if (wild) begin
      s = {8'($urandom), $urandom};
    end else begin
      s.pedal1 = 10'($urandom_range(P1WideLo, P1WideHi));
      // keep pedal two near pedal one half of the time so the cuts clear
      s.pedal2 = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(P2WideLo, P2WideHi))
                 : 10'($urandom_range(P2WideLo, P2WideHi - 100));
      if ($urandom_range(0, 1) == 1) s.pedal2 = 10'(s.pedal1 + 90 + $urandom_range(0, 20));
      s.steer = 10'($urandom_range(StWideLo, StWideHi));
      s.brake = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                : 10'($urandom_range(0, 480));
    end
    return s;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_sample(rand_sample($urandom_range(0, 9) == 0), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: wide limits at and past their edges, steering both ways,
    // pedals at their low limits, brake latch and cut.
    send_sample({10'd0, 10'd500, 10'd200, 10'd100}, 0);    // pedals at low limits
    send_sample({10'd0, 10'd500, 10'd900, 10'd800}, 0);    // full pedal, straight
    send_sample({10'd0, 10'd900, 10'd900, 10'd800}, 0);    // full right lock
    send_sample({10'd0, 10'd100, 10'd900, 10'd800}, 0);    // full left lock
    send_sample({10'd1023, 10'd899, 10'd950, 10'd850}, 0); // wide edges, brake latches
    send_sample({10'd0, 10'd500, 10'd150, 10'd49}, 0);     // pedal one too low
    send_sample({10'd0, 10'd500, 10'd150, 10'd851}, 0);    // pedal one too high
    send_sample({10'd0, 10'd500, 10'd149, 10'd400}, 0);    // pedal two too low
    send_sample({10'd0, 10'd500, 10'd951, 10'd400}, 0);    // pedal two too high
    send_sample({10'd0, 10'd99, 10'd500, 10'd400}, 0);     // steering too low
    send_sample({10'd0, 10'd901, 10'd500, 10'd400}, 0);    // steering too high
    send_sample({10'd600, 10'd500, 10'd800, 10'd700}, 0);  // hard brake, still latched
    send_sample({10'd500, 10'd500, 10'd800, 10'd700}, 0);  // latched, brake cut
    send_sample({10'd0, 10'd500, 10'd210, 10'd110}, 0);    // low pedal clears latch
    for (int i = 0; i < DisagreeDelay + 2; i++)            // persistent disagreement
      send_sample({10'd0, 10'd500, 10'd200, 10'd700}, 1);
    send_sample({10'd0, 10'd500, 10'd600, 10'd500}, 0);    // agreement clears
    drain();

    // Brake hold long enough to reach the delay.
    for (int i = 0; i < BrakeDelay + 3; i++)
      send_sample({10'd700, 10'($urandom_range(100, 900)), 10'd800, 10'd700}, 1);
    send_sample({10'd0, 10'd500, 10'd200, 10'd100}, 0);

    // Reset config with random traffic; receiver holds off while sender pushes.
    hold_off = 1;
    random_phase(150);
    drain();

    // Degenerate spans and extremes.
    write_reg(REG_P1_LO, 10'd1023);
    write_reg(REG_P1_HI, 10'd0);
    write_reg(REG_P2_LO, 10'd0);
    write_reg(REG_P2_HI, 10'd1023);
    write_reg(REG_ST_LE, 10'd0);
    write_reg(REG_ST_RE, 10'd1023);
    write_reg(REG_ST_LF, 10'd1023);
    write_reg(REG_ST_RF, 10'd0);
    random_phase(80);
    drain();

    // Full and narrow pedal spans, steering sides that cannot reach full lock.
    write_reg(REG_P1_LO, 10'd0);
    write_reg(REG_P1_HI, 10'd1023);
    write_reg(REG_P2_LO, 10'd500);
    write_reg(REG_P2_HI, 10'd501);
    write_reg(REG_ST_LE, 10'd500);
    write_reg(REG_ST_RE, 10'd500);
    write_reg(REG_ST_LF, 10'd600);
    write_reg(REG_ST_RF, 10'd400);
    random_phase(60);
    drain();

    // Random in-range settings.
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < NumRegs; r++) write_reg(3'(r), 10'($urandom_range(0, 1023)));
      random_phase(30);
      drain();
    end

    // Back to a usual setting and finish.
    write_reg(REG_P1_LO, 10'd100);
    write_reg(REG_P1_HI, 10'd800);
    write_reg(REG_P2_LO, 10'd200);
    write_reg(REG_P2_HI, 10'd900);
    write_reg(REG_ST_LE, 10'd490);
    write_reg(REG_ST_RE, 10'd510);
    write_reg(REG_ST_LF, 10'd200);
    write_reg(REG_ST_RF, 10'd800);
    random_phase(50);
    drain();

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
